@@ rtl/mbs_pkg.sv @@
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants of the mip-mapped bilinear sampler.
// ----------------------------------------------------------------------------
package mbs_pkg;

  // Pyramid shape
  localparam int NUM_LEVELS = 5;
  localparam int LVL_W      = 3;

  // Configuration port
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_THREE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR  = 3'd5;

  // Reset values, unsigned Q4.12
  localparam logic [REG_W-1:0] RST_SCALE     = 16'd4096;
  localparam logic [REG_W-1:0] RST_THR_ONE   = 16'd2458;
  localparam logic [REG_W-1:0] RST_THR_TWO   = 16'd1434;
  localparam logic [REG_W-1:0] RST_THR_THREE = 16'd614;
  localparam logic [REG_W-1:0] RST_THR_FOUR  = 16'd205;
  localparam logic [REG_W-1:0] SCALE_ONE     = 16'd4096;

  // Item kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Coordinate format
  localparam int COORD_W = 17;
  localparam int FRAC_W  = 15;
  localparam int WGT_W   = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } texel_t;

endpackage

@@ rtl/mbs_bank_ram.sv @@
// ----------------------------------------------------------------------------
// mbs_bank_ram
// One texel bank: single address, synchronous write, registered read.
// ----------------------------------------------------------------------------
module mbs_bank_ram #(
  parameter  int DEPTH = 1364,
  parameter  int DW    = 24,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/mbs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mbs_cfg_regs
// Scale and threshold registers, and the mip level they select.
// ----------------------------------------------------------------------------
module mbs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [mbs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [mbs_pkg::REG_W-1:0]     wr_data,
  output logic [mbs_pkg::LVL_W-1:0]     level
);
  import mbs_pkg::*;

  typedef struct packed {
    logic [REG_W-1:0] scale_x;
    logic [REG_W-1:0] scale_y;
    logic [REG_W-1:0] thr_one;
    logic [REG_W-1:0] thr_two;
    logic [REG_W-1:0] thr_three;
    logic [REG_W-1:0] thr_four;
  } cfg_t;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [REG_W-1:0] scale_min;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_SCALE_X:   cfg_nxt.scale_x   = wr_data;
        REG_SCALE_Y:   cfg_nxt.scale_y   = wr_data;
        REG_THR_ONE:   cfg_nxt.thr_one   = wr_data;
        REG_THR_TWO:   cfg_nxt.thr_two   = wr_data;
        REG_THR_THREE: cfg_nxt.thr_three = wr_data;
        REG_THR_FOUR:  cfg_nxt.thr_four  = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x   <= RST_SCALE;
      cfg_r.scale_y   <= RST_SCALE;
      cfg_r.thr_one   <= RST_THR_ONE;
      cfg_r.thr_two   <= RST_THR_TWO;
      cfg_r.thr_three <= RST_THR_THREE;
      cfg_r.thr_four  <= RST_THR_FOUR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Finest level wins at unit scale; otherwise the coarsest level whose threshold holds
  always_comb begin
    scale_min = (cfg_r.scale_x < cfg_r.scale_y) ? cfg_r.scale_x : cfg_r.scale_y;
    priority if (scale_min >= SCALE_ONE) begin
      level = 3'd0;
    end else if (scale_min <= cfg_r.thr_four) begin
      level = 3'd4;
    end else if (scale_min <= cfg_r.thr_three) begin
      level = 3'd3;
    end else if (scale_min <= cfg_r.thr_two) begin
      level = 3'd2;
    end else if (scale_min <= cfg_r.thr_one) begin
      level = 3'd1;
    end else begin
      level = 3'd0;
    end
  end

endmodule

@@ rtl/mipmap_bilinear_sampler_core.sv @@
// ----------------------------------------------------------------------------
// mipmap_bilinear_sampler_core
// Five-level RGB mip pyramid with a bilinear sampling pipeline.
//
// Input channel (in_*): a write item stores one texel at (level, x, y); a
// sample item filters the pyramid at (coord_u, coord_v) on the level picked
// from the scale registers. Writes outside a level's side are dropped.
// Output channel (out_*): one filtered color and the level used per sample;
// writes give nothing. Config channel (cfg_*): always ready, one register per
// accepted beat; write it only while no item is in flight.
// Throughput: one item per cycle while out_ready stays high. Seven register
// stages lie from accept to out_valid (level pick, coordinate multiply,
// clamp, bank address, bank read, x blend, y blend), the first loaded at the
// accept edge.
// The texture is split into four banks by x and y parity, so the four
// neighbors of a sample always land in four different banks, one read each.
// Reset: valid bits clear and config registers load their defaults; texel
// contents stay undefined until written, with no clearing pass.
// Stall: a low out_ready holds the output and fills the empty stages behind
// it; in_ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module mipmap_bilinear_sampler_core #(
  parameter int BASE_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [2:0]                          in_write_level,
  input  logic [5:0]                          in_write_x,
  input  logic [5:0]                          in_write_y,
  input  logic [7:0]                          in_write_red,
  input  logic [7:0]                          in_write_green,
  input  logic [7:0]                          in_write_blue,
  input  logic signed [mbs_pkg::COORD_W-1:0]  in_coord_u,
  input  logic signed [mbs_pkg::COORD_W-1:0]  in_coord_v,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic [mbs_pkg::LVL_W-1:0]           out_chosen_level,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbs_pkg::REG_W-1:0]           cfg_data
);
  import mbs_pkg::*;

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int SIDE_W    = $clog2(BASE_SIZE + 1);   // holds a side value
  localparam int IDX_W     = $clog2(BASE_SIZE);       // texel column or row
  localparam int PW        = COORD_W + SIDE_W + 1;    // coord * side
  localparam int CW        = (SIDE_W > 6) ? SIDE_W : 6;
  localparam int NUM_BANKS = 4;
  localparam int TEX_W     = $bits(texel_t);

  // Rows and columns per bank at one level (ceiling of half the side)
  function automatic int half_side(input int l);
    return ((BASE_SIZE >> l) + 1) >> 1;
  endfunction

  // First bank entry of a level
  function automatic int level_base(input int l);
    int acc;
    acc = 0;
    for (int k = 0; k < l; k++) begin
      acc += half_side(k) * half_side(k);
    end
    return acc;
  endfunction

  localparam int BANK_DEPTH = level_base(NUM_LEVELS);
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int QBASE [NUM_LEVELS] =
    '{level_base(0), level_base(1), level_base(2), level_base(3), level_base(4)};
  localparam int HQ [NUM_LEVELS] =
    '{half_side(0), half_side(1), half_side(2), half_side(3), half_side(4)};

  function automatic logic [SIDE_W-1:0] side_of(input logic [LVL_W-1:0] lvl);
    return SIDE_W'(BASE_SIZE >> lvl);
  endfunction

  // --------------------------------------------------------------------------
  // Stage payloads
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] n;
    logic [WGT_W-1:0] w;
  } place_t;

  typedef struct packed {
    logic               sample;
    logic               ok;
    logic [LVL_W-1:0]   lvl;
    logic [5:0]         wx;
    logic [5:0]         wy;
    texel_t             tex;
    logic [COORD_W-1:0] cu;
    logic [COORD_W-1:0] cv;
  } s1_t;

  typedef struct packed {
    logic             sample;
    logic             ok;
    logic [LVL_W-1:0] lvl;
    logic [5:0]       wx;
    logic [5:0]       wy;
    texel_t           tex;
    logic [PW-1:0]    pu;
    logic [PW-1:0]    pv;
  } s2_t;

  typedef struct packed {
    logic             sample;
    logic             ok;
    logic [LVL_W-1:0] lvl;
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] iy;
    logic [IDX_W-1:0] ny;
    logic [WGT_W-1:0] wu;
    logic [WGT_W-1:0] wv;
    texel_t           tex;
  } s3_t;

  typedef struct packed {
    logic                                 sample;
    logic                                 ok;
    logic [LVL_W-1:0]                     lvl;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]    addr;
    logic [1:0]                           wbank;
    logic                                 ix0;
    logic                                 nx0;
    logic                                 iy0;
    logic                                 ny0;
    logic [WGT_W-1:0]                     wu;
    logic [WGT_W-1:0]                     wv;
    texel_t                               tex;
  } s4_t;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic             ix0;
    logic             nx0;
    logic             iy0;
    logic             ny0;
    logic [WGT_W-1:0] wu;
    logic [WGT_W-1:0] wv;
  } s5_t;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    texel_t           top;
    texel_t           bot;
    logic [WGT_W-1:0] wv;
  } s6_t;

  // Clamp coord*side, split into index and weight, pick the neighbor
  function automatic place_t place_f(input logic [PW-1:0] p, input logic [SIDE_W-1:0] side);
    place_t         r;
    logic [PW-1:0]  lim;
    logic [IDX_W:0] ip1;
    logic [IDX_W:0] side_e;
    lim    = PW'({side, {FRAC_W{1'b0}}});
    side_e = (IDX_W + 1)'(side);
    if ($signed(p) >= $signed(lim)) begin
      r.i = IDX_W'(side - 1'b1);
      r.w = '0;
    end else if (p[PW-1]) begin
      r.i = '0;
      r.w = '0;
    end else begin
      r.i = p[FRAC_W +: IDX_W];
      r.w = p[FRAC_W-1 -: WGT_W];
    end
    // Mirror inward at the last texel; a one-texel side uses itself
    ip1 = {1'b0, r.i} + 1'b1;
    if (ip1 >= side_e) begin
      r.n = (r.i != '0) ? r.i - 1'b1 : r.i;
    end else begin
      r.n = ip1[IDX_W-1:0];
    end
    return r;
  endfunction

  // Truncating linear blend of one channel
  function automatic logic [7:0] mix_f(input logic [7:0] a, input logic [7:0] b,
                                       input logic [WGT_W-1:0] w);
    logic [16:0] acc;
    acc = 17'(b) * 17'(w) + 17'(a) * (17'd256 - 17'(w));
    return acc[15:8];
  endfunction

  function automatic texel_t blend_f(input texel_t a, input texel_t b,
                                     input logic [WGT_W-1:0] w);
    texel_t r;
    r.red   = mix_f(a.red,   b.red,   w);
    r.green = mix_f(a.green, b.green, w);
    r.blue  = mix_f(a.blue,  b.blue,  w);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [LVL_W-1:0] pick_lvl;

  assign cfg_ready = 1'b1;

  mbs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .level    (pick_lvl)
  );

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its item moves on
  // --------------------------------------------------------------------------
  logic [6:1] v_r;
  logic [6:1] rdy;
  logic       rdy_out;
  logic       out_valid_r;

  assign rdy_out = !out_valid_r || out_ready;
  assign rdy[6]  = !v_r[6] || rdy_out;
  assign rdy[5]  = !v_r[5] || rdy[6];
  assign rdy[4]  = !v_r[4] || rdy[5];
  assign rdy[3]  = !v_r[3] || rdy[4];
  assign rdy[2]  = !v_r[2] || rdy[3];
  assign rdy[1]  = !v_r[1] || rdy[2];
  assign in_ready = rdy[1];

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;
  texel_t           out_tex_r, out_tex_nxt;
  logic [LVL_W-1:0] out_lvl_r;

  // --------------------------------------------------------------------------
  // Stage 1: level pick and write range check
  // --------------------------------------------------------------------------
  logic              wl_ok;
  logic [SIDE_W-1:0] w_side;

  always_comb begin
    s1_nxt.sample    = (in_action == ACT_SAMPLE);
    wl_ok            = in_write_level < LVL_W'(NUM_LEVELS);
    w_side           = side_of(wl_ok ? in_write_level : '0);
    s1_nxt.ok        = wl_ok && (CW'(in_write_x) < CW'(w_side))
                             && (CW'(in_write_y) < CW'(w_side));
    s1_nxt.lvl       = s1_nxt.sample ? pick_lvl : (wl_ok ? in_write_level : '0);
    s1_nxt.wx        = in_write_x;
    s1_nxt.wy        = in_write_y;
    s1_nxt.tex.red   = in_write_red;
    s1_nxt.tex.green = in_write_green;
    s1_nxt.tex.blue  = in_write_blue;
    s1_nxt.cu        = in_coord_u;
    s1_nxt.cv        = in_coord_v;
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale coordinates by the level's side
  // --------------------------------------------------------------------------
  logic [SIDE_W-1:0] s2_side;
  logic signed [PW-1:0] pu_s, pv_s;

  always_comb begin
    s2_side = side_of(s1_r.lvl);
    pu_s    = $signed(s1_r.cu) * $signed({1'b0, s2_side});
    pv_s    = $signed(s1_r.cv) * $signed({1'b0, s2_side});
    s2_nxt.sample = s1_r.sample;
    s2_nxt.ok     = s1_r.ok;
    s2_nxt.lvl    = s1_r.lvl;
    s2_nxt.wx     = s1_r.wx;
    s2_nxt.wy     = s1_r.wy;
    s2_nxt.tex    = s1_r.tex;
    s2_nxt.pu     = pu_s;
    s2_nxt.pv     = pv_s;
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamp, weights, neighbors; a write uses its own texel four times
  // --------------------------------------------------------------------------
  place_t            pl_u, pl_v;
  logic [SIDE_W-1:0] s3_side;

  always_comb begin
    s3_side = side_of(s2_r.lvl);
    pl_u    = place_f(s2_r.pu, s3_side);
    pl_v    = place_f(s2_r.pv, s3_side);
    s3_nxt.sample = s2_r.sample;
    s3_nxt.ok     = s2_r.ok;
    s3_nxt.lvl    = s2_r.lvl;
    s3_nxt.tex    = s2_r.tex;
    if (s2_r.sample) begin
      s3_nxt.ix = pl_u.i;
      s3_nxt.nx = pl_u.n;
      s3_nxt.iy = pl_v.i;
      s3_nxt.ny = pl_v.n;
      s3_nxt.wu = pl_u.w;
      s3_nxt.wv = pl_v.w;
    end else begin
      s3_nxt.ix = IDX_W'(s2_r.wx);
      s3_nxt.nx = IDX_W'(s2_r.wx);
      s3_nxt.iy = IDX_W'(s2_r.wy);
      s3_nxt.ny = IDX_W'(s2_r.wy);
      s3_nxt.wu = '0;
      s3_nxt.wv = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: bank addresses; bank {row parity, column parity}
  // --------------------------------------------------------------------------
  logic [BANK_AW-1:0]     qb, hq, off_i, off_n, row_off;
  logic [IDX_W-2:0]       col_h;
  logic [1:0]             bsel;

  always_comb begin
    qb    = BANK_AW'(QBASE[s3_r.lvl]);
    hq    = BANK_AW'(HQ[s3_r.lvl]);
    off_i = BANK_AW'(s3_r.iy[IDX_W-1:1]) * hq;
    off_n = BANK_AW'(s3_r.ny[IDX_W-1:1]) * hq;
    s4_nxt.sample = s3_r.sample;
    s4_nxt.ok     = s3_r.ok;
    s4_nxt.lvl    = s3_r.lvl;
    s4_nxt.wbank  = {s3_r.iy[0], s3_r.ix[0]};
    s4_nxt.ix0    = s3_r.ix[0];
    s4_nxt.nx0    = s3_r.nx[0];
    s4_nxt.iy0    = s3_r.iy[0];
    s4_nxt.ny0    = s3_r.ny[0];
    s4_nxt.wu     = s3_r.wu;
    s4_nxt.wv     = s3_r.wv;
    s4_nxt.tex    = s3_r.tex;
    s4_nxt.addr   = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bsel    = 2'(b);
      col_h   = (s3_r.ix[0] == bsel[0]) ? s3_r.ix[IDX_W-1:1] : s3_r.nx[IDX_W-1:1];
      row_off = (s3_r.iy[0] == bsel[1]) ? off_i : off_n;
      s4_nxt.addr[b] = qb + row_off + BANK_AW'(col_h);
    end
  end

  // --------------------------------------------------------------------------
  // Texel banks: a write item stores, a sample item reads all four
  // --------------------------------------------------------------------------
  logic [NUM_BANKS-1:0]            bank_we;
  logic [NUM_BANKS-1:0][TEX_W-1:0] bank_rd;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    assign bank_we[b] = v_r[4] && rdy[5] && !s4_r.sample && s4_r.ok
                        && (s4_r.wbank == 2'(b));

    mbs_bank_ram #(
      .DEPTH (BANK_DEPTH),
      .DW    (TEX_W)
    ) u_ram (
      .clk     (clk),
      .we      (bank_we[b]),
      .re      (rdy[5]),
      .addr    (s4_r.addr[b]),
      .wdata   (s4_r.tex),
      .rd_data (bank_rd[b])
    );
  end

  always_comb begin
    s5_nxt.lvl = s4_r.lvl;
    s5_nxt.ix0 = s4_r.ix0;
    s5_nxt.nx0 = s4_r.nx0;
    s5_nxt.iy0 = s4_r.iy0;
    s5_nxt.ny0 = s4_r.ny0;
    s5_nxt.wu  = s4_r.wu;
    s5_nxt.wv  = s4_r.wv;
  end

  // --------------------------------------------------------------------------
  // Stage 6: blend along x, top and bottom rows
  // --------------------------------------------------------------------------
  texel_t t1, t2, t3, t4;

  always_comb begin
    t1 = texel_t'(bank_rd[{s5_r.iy0, s5_r.ix0}]);
    t2 = texel_t'(bank_rd[{s5_r.iy0, s5_r.nx0}]);
    t3 = texel_t'(bank_rd[{s5_r.ny0, s5_r.ix0}]);
    t4 = texel_t'(bank_rd[{s5_r.ny0, s5_r.nx0}]);
    s6_nxt.lvl = s5_r.lvl;
    s6_nxt.top = blend_f(t1, t2, s5_r.wu);
    s6_nxt.bot = blend_f(t3, t4, s5_r.wu);
    s6_nxt.wv  = s5_r.wv;
  end

  // Output: blend along y
  assign out_tex_nxt = blend_f(s6_r.top, s6_r.bot, s6_r.wv);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
      // drop write items once their texel is stored
      if (rdy[5]) v_r[5] <= v_r[4] && s4_r.sample;
      if (rdy[6]) v_r[6] <= v_r[5];
      if (rdy_out) out_valid_r <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) s1_r <= s1_nxt;
    if (rdy[2]) s2_r <= s2_nxt;
    if (rdy[3]) s3_r <= s3_nxt;
    if (rdy[4]) s4_r <= s4_nxt;
    if (rdy[5]) s5_r <= s5_nxt;
    if (rdy[6]) s6_r <= s6_nxt;
    if (rdy_out) begin
      out_tex_r <= out_tex_nxt;
      out_lvl_r <= s6_r.lvl;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_tex_r.red;
  assign out_green        = out_tex_r.green;
  assign out_blue         = out_tex_r.blue;
  assign out_chosen_level = out_lvl_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // Input stalls only when every stage is full and the output is held
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r == '1) && out_valid_r && !out_ready)
    else $error("input stalled with an empty pipeline stage");

  // Clamped texel indices stay inside the chosen level
  a_index_in_level: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && s3_r.sample) |->
      ((IDX_W + 1)'(s3_r.ix) < (IDX_W + 1)'(side_of(s3_r.lvl))) &&
      ((IDX_W + 1)'(s3_r.nx) < (IDX_W + 1)'(side_of(s3_r.lvl))) &&
      ((IDX_W + 1)'(s3_r.iy) < (IDX_W + 1)'(side_of(s3_r.lvl))) &&
      ((IDX_W + 1)'(s3_r.ny) < (IDX_W + 1)'(side_of(s3_r.lvl))))
    else $error("sample index outside its level");

  // A stalled read stage keeps its item and metadata
  a_read_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && !rdy[6]) |=> v_r[5] && $stable(s5_r))
    else $error("read stage lost its item during a stall");

  // At most one bank is written per cycle
  a_single_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("more than one texel bank written");

  // Results report a real level
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_lvl_r < LVL_W'(NUM_LEVELS)))
    else $error("result level outside the pyramid");
`endif

endmodule

@@ dv/mbs_filter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbs_filter_checker
// Watches the item, result and register channels of the mip-mapped bilinear
// sampler, keeps its own copy of the pyramid and the registers, predicts the
// filtered color of every sample and compares each result field by field.
// ----------------------------------------------------------------------------
module mbs_filter_checker #(
  parameter int BASE_SIZE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_action,
  input  logic [2:0]                         in_write_level,
  input  logic [5:0]                         in_write_x,
  input  logic [5:0]                         in_write_y,
  input  logic [7:0]                         in_write_red,
  input  logic [7:0]                         in_write_green,
  input  logic [7:0]                         in_write_blue,
  input  logic signed [mbs_pkg::COORD_W-1:0] in_coord_u,
  input  logic signed [mbs_pkg::COORD_W-1:0] in_coord_v,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [7:0]                         out_red,
  input  logic [7:0]                         out_green,
  input  logic [7:0]                         out_blue,
  input  logic [mbs_pkg::LVL_W-1:0]          out_chosen_level,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbs_pkg::REG_W-1:0]          cfg_data,
  output int                                 pending,
  output int                                 mismatches
);
  import mbs_pkg::*;

  localparam int DEPTH = BASE_SIZE * BASE_SIZE + (BASE_SIZE / 2) * (BASE_SIZE / 2) +
                         (BASE_SIZE / 4) * (BASE_SIZE / 4) + (BASE_SIZE / 8) * (BASE_SIZE / 8) +
                         (BASE_SIZE / 16) * (BASE_SIZE / 16);

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [LVL_W-1:0] level;
  } filtered_t;

  typedef struct {
    int idx;
    int nbr;
    int wgt;
  } axis_t;

  texel_t           texel_mirror [DEPTH];
  filtered_t        expected_colors [$];
  logic [REG_W-1:0] scale_x_q, scale_y_q;
  logic [REG_W-1:0] thr_one_q, thr_two_q, thr_three_q, thr_four_q;

  function automatic int level_base(input int lvl);
    int off;
    off = 0;
    for (int l = 0; l < lvl; l++) begin
      off += (BASE_SIZE >> l) * (BASE_SIZE >> l);
    end
    return off;
  endfunction

  // Smaller scale against the thresholds, finest level last.
  function automatic logic [LVL_W-1:0] pick_level();
    logic [REG_W-1:0] s;
    s = (scale_x_q < scale_y_q) ? scale_x_q : scale_y_q;
    if (s >= SCALE_ONE) return 3'd0;
    if (s <= thr_four_q) return 3'd4;
    if (s <= thr_three_q) return 3'd3;
    if (s <= thr_two_q) return 3'd2;
    if (s <= thr_one_q) return 3'd1;
    return 3'd0;
  endfunction

  // Clamp coord*side, split into texel, inward neighbor and 8-bit weight.
  function automatic axis_t locate(input logic signed [COORD_W-1:0] c, input int side);
    axis_t  a;
    longint p;
    longint lim;
    p   = longint'(c) * longint'(side);
    lim = longint'(side) <<< FRAC_W;
    if (p >= lim) p = longint'(side - 1) <<< FRAC_W;
    if (p < 0) p = 0;
    a.idx = int'(p >>> FRAC_W);
    a.wgt = int'(p & 64'h7FFF) >> (FRAC_W - WGT_W);
    if (a.idx + 1 >= side) a.nbr = (a.idx > 0) ? a.idx - 1 : a.idx;
    else a.nbr = a.idx + 1;
    return a;
  endfunction

  function automatic logic [7:0] blend(input int a, input int b, input int w);
    return 8'((b * w + a * (256 - w)) >> 8);
  endfunction

  function automatic filtered_t filter_sample(input logic signed [COORD_W-1:0] u,
                                              input logic signed [COORD_W-1:0] v);
    filtered_t f;
    axis_t     ax, ay;
    texel_t    t1, t2, t3, t4;
    int        side, base;
    f.level = pick_level();
    side    = BASE_SIZE >> f.level;
    base    = level_base(f.level);
    ax      = locate(u, side);
    ay      = locate(v, side);
    t1      = texel_mirror[base + ay.idx * side + ax.idx];
    t2      = texel_mirror[base + ay.idx * side + ax.nbr];
    t3      = texel_mirror[base + ay.nbr * side + ax.idx];
    t4      = texel_mirror[base + ay.nbr * side + ax.nbr];
    f.red   = blend(blend(t1.red, t2.red, ax.wgt), blend(t3.red, t4.red, ax.wgt), ay.wgt);
    f.green = blend(blend(t1.green, t2.green, ax.wgt), blend(t3.green, t4.green, ax.wgt),
                    ay.wgt);
    f.blue  = blend(blend(t1.blue, t2.blue, ax.wgt), blend(t3.blue, t4.blue, ax.wgt), ay.wgt);
    return f;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    filtered_t want;
    int        side;
    if (!rst_n) begin
      scale_x_q   = RST_SCALE;
      scale_y_q   = RST_SCALE;
      thr_one_q   = RST_THR_ONE;
      thr_two_q   = RST_THR_TWO;
      thr_three_q = RST_THR_THREE;
      thr_four_q  = RST_THR_FOUR;
      expected_colors.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE_X:   scale_x_q   = cfg_data;
          REG_SCALE_Y:   scale_y_q   = cfg_data;
          REG_THR_ONE:   thr_one_q   = cfg_data;
          REG_THR_TWO:   thr_two_q   = cfg_data;
          REG_THR_THREE: thr_three_q = cfg_data;
          REG_THR_FOUR:  thr_four_q  = cfg_data;
          default: ;
        endcase
      end
      // Results leave in order, so the oldest expectation is the one to match.
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("result with no sample outstanding: level %0d color %0d/%0d/%0d",
                 out_chosen_level, out_red, out_green, out_blue);
          mismatches++;
        end else begin
          want = expected_colors.pop_front();
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("chosen_level", 8'(want.level), 8'(out_chosen_level));
        end
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_SAMPLE) begin
          expected_colors.push_back(filter_sample(in_coord_u, in_coord_v));
        end else if (in_write_level < NUM_LEVELS) begin
          side = BASE_SIZE >> in_write_level;
          if (in_write_x < side && in_write_y < side) begin
            texel_mirror[level_base(in_write_level) + in_write_y * side + in_write_x] =
              '{in_write_red, in_write_green, in_write_blue};
          end
        end
      end
    end
    pending <= expected_colors.size();
  end

endmodule

@@ dv/mipmap_bilinear_sampler_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_bilinear_sampler_core_tb
// Loads the border texels of every level, runs directed corner samples and
// writes, then random phases under several level settings and idling
// patterns. A checker beside the block predicts every filtered color; this
// top drives items and register writes and reports the verdict.
// ----------------------------------------------------------------------------
module mipmap_bilinear_sampler_core_tb;
  import mbs_pkg::*;

  localparam int BASE_SIZE       = 64;
  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 80;
  // pipeline is 7 deep; give writes still in flight room to retire
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int COORD_LOW       = -65536;
  localparam int COORD_HIGH      = 65535;
  localparam int COORD_ONE       = 32768;
  // coordinates below this stay on the first texel of every level
  localparam int LOW_SPAN        = COORD_ONE / BASE_SIZE;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic                      action;
    logic [2:0]                level;
    logic [5:0]                x;
    logic [5:0]                y;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
  } texel_req_t;

  typedef struct packed {
    logic [REG_W-1:0] scale_x;
    logic [REG_W-1:0] scale_y;
    logic [REG_W-1:0] thr_one;
    logic [REG_W-1:0] thr_two;
    logic [REG_W-1:0] thr_three;
    logic [REG_W-1:0] thr_four;
  } level_setting_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_action;
  logic [2:0]                in_write_level;
  logic [5:0]                in_write_x;
  logic [5:0]                in_write_y;
  logic [7:0]                in_write_red;
  logic [7:0]                in_write_green;
  logic [7:0]                in_write_blue;
  logic signed [COORD_W-1:0] in_coord_u;
  logic signed [COORD_W-1:0] in_coord_v;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                out_red;
  logic [7:0]                out_green;
  logic [7:0]                out_blue;
  logic [LVL_W-1:0]          out_chosen_level;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [REG_W-1:0]          cfg_data;

  int   pending;
  int   mismatches;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   cycle_count    = 0;
  logic receiver_hold  = 1'b0;
  event hold_start;

  mipmap_bilinear_sampler_core #(
    .BASE_SIZE(BASE_SIZE)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_write_level  (in_write_level),
    .in_write_x      (in_write_x),
    .in_write_y      (in_write_y),
    .in_write_red    (in_write_red),
    .in_write_green  (in_write_green),
    .in_write_blue   (in_write_blue),
    .in_coord_u      (in_coord_u),
    .in_coord_v      (in_coord_v),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_chosen_level(out_chosen_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  mbs_filter_checker #(
    .BASE_SIZE(BASE_SIZE)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_write_level  (in_write_level),
    .in_write_x      (in_write_x),
    .in_write_y      (in_write_y),
    .in_write_red    (in_write_red),
    .in_write_green  (in_write_green),
    .in_write_blue   (in_write_blue),
    .in_coord_u      (in_coord_u),
    .in_coord_v      (in_coord_v),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_chosen_level(out_chosen_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .mismatches      (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mipmap_bilinear_sampler_core regression: fail");
      $finish;
    end
  end

  // Result side: stall at random, or hold off completely during a hold window.
  always @(negedge clk) begin
    out_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold-off: count the window here while the sender keeps offering items,
  // so the pipeline fills and in_ready must drop.
  always begin
    @(hold_start);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    receiver_hold <= 1'b0;
  end

  function automatic texel_req_t write_req(input int lvl, input int x, input int y,
                                           input int r, input int g, input int b);
    texel_req_t q;
    q.action = ACT_WRITE;
    q.level  = 3'(lvl);
    q.x      = 6'(x);
    q.y      = 6'(y);
    q.red    = 8'(r);
    q.green  = 8'(g);
    q.blue   = 8'(b);
    q.u      = '0;
    q.v      = '0;
    return q;
  endfunction

  function automatic texel_req_t sample_req(input int u, input int v);
    texel_req_t q;
    q        = write_req(0, 0, 0, 0, 0, 0);
    q.action = ACT_SAMPLE;
    q.u      = COORD_W'(u);
    q.v      = COORD_W'(v);
    return q;
  endfunction

  // Two outer rows or columns on each side of a level: 0, 1, side-2, side-1.
  function automatic int border_pos(input int k, input int side);
    return (k < 2) ? k : side - 4 + k;
  endfunction

  // Coordinates that stay on the border texels at every level: inside the
  // first base texel, inside the last base texel, or beyond either clamp.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int r;
    r = int'($urandom_range(3));
    case (r)
      0:       return COORD_W'(int'($urandom_range(LOW_SPAN - 1)));
      1:       return COORD_W'(COORD_ONE - 1 - int'($urandom_range(LOW_SPAN - 1)));
      2:       return COORD_W'(COORD_LOW + int'($urandom_range(-COORD_LOW - 1)));
      default: return COORD_W'(COORD_ONE + int'($urandom_range(COORD_HIGH - COORD_ONE)));
    endcase
  endfunction

  // Random item: 60% samples, writes mostly in range, some landing nowhere.
  function automatic texel_req_t random_req();
    texel_req_t q;
    int         side;
    q.action = ($urandom_range(99) < 60) ? ACT_SAMPLE : ACT_WRITE;
    q.level  = 3'($urandom_range(7));
    q.x      = 6'($urandom());
    q.y      = 6'($urandom());
    q.red    = 8'($urandom());
    q.green  = 8'($urandom());
    q.blue   = 8'($urandom());
    q.u      = rand_coord();
    q.v      = rand_coord();
    if (q.action == ACT_WRITE && $urandom_range(99) < 85) begin
      q.level = 3'($urandom_range(NUM_LEVELS - 1));
      side    = BASE_SIZE >> q.level;
      q.x     = 6'($urandom_range(side - 1));
      q.y     = 6'($urandom_range(side - 1));
    end
    return q;
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 76; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      IDLE_BOTH:     begin send_idle_pct = 9;  recv_stall_pct = 9;  end
    endcase
  endtask

  // Offer one item: idle a random number of cycles, then hold it until taken.
  task automatic offer(input texel_req_t q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= q.action;
    in_write_level <= q.level;
    in_write_x     <= q.x;
    in_write_y     <= q.y;
    in_write_red   <= q.red;
    in_write_green <= q.green;
    in_write_blue  <= q.blue;
    in_coord_u     <= q.u;
    in_coord_v     <= q.v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(input level_setting_t s);
    write_reg(REG_SCALE_X, s.scale_x);
    write_reg(REG_SCALE_Y, s.scale_y);
    write_reg(REG_THR_ONE, s.thr_one);
    write_reg(REG_THR_TWO, s.thr_two);
    write_reg(REG_THR_THREE, s.thr_three);
    write_reg(REG_THR_FOUR, s.thr_four);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait out every expected result, then let trailing writes retire.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    level_setting_t settings [NUM_PHASES];
    idle_mode_t     modes [NUM_PHASES];
    texel_req_t     q;
    int             landed;
    int             side;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_WRITE;
    in_write_level = '0;
    in_write_x     = '0;
    in_write_y     = '0;
    in_write_red   = '0;
    in_write_green = '0;
    in_write_blue  = '0;
    in_coord_u     = '0;
    in_coord_v     = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_SCALE_X;
    cfg_data       = '0;

    // Settings chosen to land on every level, plus register extremes.
    settings[0]  = '{RST_SCALE, RST_SCALE, RST_THR_ONE, RST_THR_TWO, RST_THR_THREE,
                     RST_THR_FOUR};                                       // level 0
    settings[1]  = '{16'd1000, 16'd3000, RST_THR_ONE, RST_THR_TWO, RST_THR_THREE,
                     RST_THR_FOUR};                                       // level 2
    settings[2]  = '{16'd0, 16'hFFFF, RST_THR_ONE, RST_THR_TWO, RST_THR_THREE,
                     RST_THR_FOUR};                                       // level 4
    settings[3]  = '{16'd500, 16'd400, RST_THR_ONE, RST_THR_TWO, RST_THR_THREE,
                     RST_THR_FOUR};                                       // level 3
    settings[4]  = '{16'd4095, 16'd2000, RST_THR_ONE, RST_THR_TWO, RST_THR_THREE,
                     RST_THR_FOUR};                                       // level 1
    settings[5]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0};  // scale >= 1.0
    settings[6]  = '{16'd4095, 16'd4095, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    settings[7]  = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0};           // no threshold holds
    settings[8]  = '{16'd4095, 16'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    for (int p = 9; p < NUM_PHASES; p++) begin
      settings[p] = '{16'($urandom_range(8191)), 16'($urandom_range(8191)),
                      16'($urandom_range(4095)), 16'($urandom_range(4095)),
                      16'($urandom_range(4095)), 16'($urandom_range(4095))};
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      modes[p] = idle_mode_t'(p % 4);
    end
    modes[PRESSURE_PHASE] = IDLE_NONE;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the border texels of every level; every sample below stays on them.
    set_idling(IDLE_NONE);
    for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
      side = BASE_SIZE >> lvl;
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          offer(write_req(lvl, border_pos(k, side), border_pos(j, side),
                          $urandom(), $urandom(), $urandom()));
        end
      end
    end

    // Directed: color extremes, corner texels, dropped writes and coordinate
    // corners on the reset level (level 0).
    offer(write_req(0, 63, 63, 255, 255, 255));
    offer(sample_req(COORD_HIGH, COORD_HIGH));     // clamp high, both edges mirror
    offer(write_req(0, 0, 0, 0, 0, 0));
    offer(sample_req(COORD_LOW, COORD_LOW));       // clamp low
    offer(write_req(4, 3, 3, 255, 0, 255));        // last texel of the smallest level
    offer(write_req(5, 0, 0, 255, 255, 255));      // level past the pyramid: drop
    offer(write_req(7, 63, 63, 0, 255, 0));        // drop
    offer(write_req(4, 4, 0, 1, 2, 3));            // column past level 4: drop
    offer(write_req(1, 0, 32, 4, 5, 6));           // row past level 1: drop
    offer(write_req(3, 63, 63, 7, 8, 9));          // drop
    offer(sample_req(COORD_ONE, 0));               // exactly 1.0 clamps to last column
    offer(sample_req(COORD_ONE - 1, COORD_ONE - 1));
    offer(sample_req(-1, 511));
    offer(sample_req(32300, -1));
    offer(sample_req(300, 32500));
    offer(sample_req(0, COORD_ONE - 1));           // last row, mirror inward
    offer(sample_req(0, 0));
    offer(sample_req(511, 255));                   // small fractions

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      load_setting(settings[p]);
      set_idling(modes[p]);
      if (p == PRESSURE_PHASE) -> hold_start;
      landed = 0;
      while (landed < ITEMS_PER_PHASE) begin
        q = random_req();
        offer(q);
        // count only items that do something: samples and writes that land
        if (q.action == ACT_SAMPLE ||
            (q.level < NUM_LEVELS && q.x < (BASE_SIZE >> q.level) &&
             q.y < (BASE_SIZE >> q.level))) begin
          landed++;
        end
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("mipmap_bilinear_sampler_core regression: pass");
    end else begin
      $display("mipmap_bilinear_sampler_core regression: fail");
    end
    $finish;
  end

endmodule
